/* src/trd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants for the triangle raster / depth test
// Item, task and result records, the back-end state encoding and depth limits.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int VTX_W   = 12;
    localparam int CRD_W   = 14;
    localparam int EDGE_W  = 32;
    localparam int Z_W     = 32;
    localparam int COLOR_W = 24;
    localparam int RIDX_W  = 16;
    localparam int CNT_W   = 17;
    localparam int FR_W    = 9;

    // quotient bits produced by the restoring divider
    localparam int DIV_STEPS = 31;

    localparam logic signed [Z_W-1:0] FAR_DEPTH  = 32'sh7fff_ffff;
    localparam logic signed [Z_W-1:0] NEAR_DEPTH = 32'sh8000_0000;

    typedef logic signed [VTX_W-1:0]  vtx_t;
    typedef logic signed [CRD_W-1:0]  crd_t;
    typedef logic signed [EDGE_W-1:0] edge_t;
    typedef logic signed [Z_W-1:0]    z_t;
    typedef logic [COLOR_W-1:0]       color_t;

    typedef enum logic [1:0] {
        KIND_DRAW = 2'd0,
        KIND_FILL = 2'd1,
        KIND_READ = 2'd2,
        KIND_NOP  = 2'd3
    } kind_e;

    typedef struct packed {
        kind_e             kind;
        vtx_t              x1;
        vtx_t              y1;
        z_t                z1;
        vtx_t              x2;
        vtx_t              y2;
        z_t                z2;
        vtx_t              x3;
        vtx_t              y3;
        z_t                z3;
        color_t            color;
        logic [RIDX_W-1:0] read_index;
    } item_t;

    typedef struct packed {
        logic [FR_W-1:0] w;
        logic [FR_W-1:0] h;
    } frame_t;

    typedef struct packed {
        kind_e             kind;
        logic              skip;
        crd_t              lo_x;
        crd_t              hi_x;
        crd_t              lo_y;
        crd_t              hi_y;
        crd_t              dx12;
        crd_t              dx23;
        crd_t              dx31;
        crd_t              dy12;
        crd_t              dy23;
        crd_t              dy31;
        edge_t             e1;
        edge_t             e2;
        edge_t             e3;
        edge_t             area;
        z_t                z1;
        z_t                z2;
        z_t                z3;
        color_t            color;
        logic [RIDX_W-1:0] read_index;
    } task_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    // color in the low bits
    typedef struct packed {
        logic [CNT_W-1:0] pixels_written;
        z_t               pixel_depth;
        color_t           pixel_color;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_RES,
        ST_FILL,
        ST_PIX,
        ST_MUL,
        ST_ABS,
        ST_SAT,
        ST_DIV,
        ST_CMP
    } bst_e;

endpackage
`default_nettype wire

/* src/triangle_raster_depth_test.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_raster_depth_test: triangle rasterizer with depth test
// Stream-in draw/fill/read words, one result word out per input word.
// ----------------------------------------------------------------------------
// After reset the block clears both stores, one pixel per cycle, over all
// MAX_WIDTH*MAX_HEIGHT pixels (65536 by default) and takes no input words
// meanwhile. A draw walks its clipped box one pixel per cycle while pixels
// are uncovered; each covered pixel holds the walk while it passes through
// the shared depth multiplier and the 31-step restoring divider (skipped
// when the quotient saturates). A fill writes one pixel per cycle. A read
// reduces its index by the store size once per wrap past it, then reads
// both stores in the pixel engine.
// Setup of the next word overlaps the current one through a two-entry queue.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test #(
    parameter int MAX_WIDTH  = trd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trd_pkg::DEF_MAX_HEIGHT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, vert3_x, vert3_y,
    // vert3_z, paint_color, read_index
    input  logic [207:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_color, pixel_depth, pixels_written, zero pad
    output logic [79:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import trd_pkg::*;

    localparam logic REG_FW = 1'b0;
    localparam logic REG_FH = 1'b1;

    logic [FR_W-1:0] fw_reg, fh_reg;
    frame_t          frame;
    item_t           item;
    task_t           push_task, head;
    logic            push, q_full, pop, q_valid, m_valid;
    back_stat_t      bstat;
    result_t         res;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FR_W'(256);
            fh_reg <= FR_W'(256);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FW:  fw_reg <= pwdata[FR_W-1:0];
                REG_FH:  fh_reg <= pwdata[FR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FW:  prdata = {{(32-FR_W){1'b0}}, fw_reg};
            REG_FH:  prdata = {{(32-FR_W){1'b0}}, fh_reg};
            default: prdata = '0;
        endcase
        frame.w = (32'(fw_reg) > MAX_WIDTH)  ? FR_W'(MAX_WIDTH)  : fw_reg;
        frame.h = (32'(fh_reg) > MAX_HEIGHT) ? FR_W'(MAX_HEIGHT) : fh_reg;
    end

    always_comb begin
        item.kind       = kind_e'(s_tuser);
        item.x1         = s_tdata[11:0];
        item.y1         = s_tdata[23:12];
        item.z1         = s_tdata[55:24];
        item.x2         = s_tdata[67:56];
        item.y2         = s_tdata[79:68];
        item.z2         = s_tdata[111:80];
        item.x3         = s_tdata[123:112];
        item.y3         = s_tdata[135:124];
        item.z3         = s_tdata[167:136];
        item.color      = s_tdata[191:168];
        item.read_index = s_tdata[207:192];
    end

    trd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .frame     (frame),
        .bstat     (bstat),
        .push      (push),
        .push_task (push_task),
        .q_full    (q_full)
    );

    trd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_task (push_task),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .valid     (q_valid)
    );

    trd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .frame   (frame),
        .q_valid (q_valid),
        .q_task  (head),
        .pop     (pop),
        .bstat   (bstat),
        .m_valid (m_valid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tvalid = m_valid;
    assign m_tdata  = {7'b0, res};

endmodule
`default_nettype wire

/* src/trd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_front: item intake and triangle setup
// Registers the incoming word, clips the bounding box, then forms the area and
// the edge values at the box corner before handing the task to the queue.
// ----------------------------------------------------------------------------
module trd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  trd_pkg::item_t     in_item,
    input  trd_pkg::frame_t    frame,
    input  trd_pkg::back_stat_t bstat,
    output logic               push,
    output trd_pkg::task_t     push_task,
    input  logic               q_full
);
    import trd_pkg::*;

    typedef logic signed [2*CRD_W-1:0] prod_t;

    function automatic crd_t min3(input crd_t a, input crd_t b, input crd_t c);
        crd_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic crd_t max3(input crd_t a, input crd_t b, input crd_t c);
        crd_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic  v1_reg, v2_reg;
    item_t it1_reg, it2_reg;
    crd_t  lox_reg, hix_reg, loy_reg, hiy_reg;
    crd_t  dx12_reg, dx23_reg, dx31_reg, dy12_reg, dy23_reg, dy31_reg;

    crd_t  x1, y1, x2, y2, x3, y3;
    crd_t  wmax, hmax, lo_x, hi_x, lo_y, hi_y;
    crd_t  sx1, sy1, sx2, sy2, sx3, sy3;
    crd_t  ddx1, ddx2, ddx3, ddy1, ddy2, ddy3;
    prod_t pa1, pb1, pa2, pb2, pa3, pb3, par, pbr;
    edge_t area;
    logic  adv2;

    // stage 1: box and edge deltas
    always_comb begin
        x1   = crd_t'(it1_reg.x1);
        y1   = crd_t'(it1_reg.y1);
        x2   = crd_t'(it1_reg.x2);
        y2   = crd_t'(it1_reg.y2);
        x3   = crd_t'(it1_reg.x3);
        y3   = crd_t'(it1_reg.y3);
        wmax = crd_t'({{(CRD_W-FR_W){1'b0}}, frame.w}) - crd_t'(1);
        hmax = crd_t'({{(CRD_W-FR_W){1'b0}}, frame.h}) - crd_t'(1);
        lo_x = min3(x1, x2, x3);
        hi_x = max3(x1, x2, x3);
        lo_y = min3(y1, y2, y3);
        hi_y = max3(y1, y2, y3);
        if (lo_x < 0) lo_x = '0;
        if (lo_y < 0) lo_y = '0;
        if (hi_x > wmax) hi_x = wmax;
        if (hi_y > hmax) hi_y = hmax;
    end

    // stage 2: area and edge values at (lo_x, lo_y)
    always_comb begin
        sx1  = crd_t'(it2_reg.x1);
        sy1  = crd_t'(it2_reg.y1);
        sx2  = crd_t'(it2_reg.x2);
        sy2  = crd_t'(it2_reg.y2);
        sx3  = crd_t'(it2_reg.x3);
        sy3  = crd_t'(it2_reg.y3);
        ddx1 = lox_reg - sx2;
        ddy1 = loy_reg - sy2;
        ddx2 = lox_reg - sx3;
        ddy2 = loy_reg - sy3;
        ddx3 = lox_reg - sx1;
        ddy3 = loy_reg - sy1;
        pa1  = dy12_reg * ddx1;
        pb1  = dx12_reg * ddy1;
        pa2  = dy23_reg * ddx2;
        pb2  = dx23_reg * ddy2;
        pa3  = dy31_reg * ddx3;
        pb3  = dx31_reg * ddy3;
        par  = dy31_reg * dx23_reg;
        pbr  = dx31_reg * dy23_reg;
        area = edge_t'(par) - edge_t'(pbr);

        push_task.kind       = it2_reg.kind;
        push_task.skip       = (area == 0) || (lox_reg > hix_reg) || (loy_reg > hiy_reg);
        push_task.lo_x       = lox_reg;
        push_task.hi_x       = hix_reg;
        push_task.lo_y       = loy_reg;
        push_task.hi_y       = hiy_reg;
        push_task.dx12       = dx12_reg;
        push_task.dx23       = dx23_reg;
        push_task.dx31       = dx31_reg;
        push_task.dy12       = dy12_reg;
        push_task.dy23       = dy23_reg;
        push_task.dy31       = dy31_reg;
        push_task.e1         = edge_t'(pa1) - edge_t'(pb1);
        push_task.e2         = edge_t'(pa2) - edge_t'(pb2);
        push_task.e3         = edge_t'(pa3) - edge_t'(pb3);
        push_task.area       = area;
        push_task.z1         = it2_reg.z1;
        push_task.z2         = it2_reg.z2;
        push_task.z3         = it2_reg.z3;
        push_task.color      = it2_reg.color;
        push_task.read_index = it2_reg.read_index;
    end

    assign push     = v2_reg && !q_full;
    assign adv2     = v1_reg && (!v2_reg || push);
    assign in_ready = !bstat.clearing && (!v1_reg || adv2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (in_valid && in_ready) v1_reg <= 1'b1;
            else if (adv2)            v1_reg <= 1'b0;
            if (adv2)                 v2_reg <= 1'b1;
            else if (push)            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) it1_reg <= in_item;
        if (adv2) begin
            it2_reg  <= it1_reg;
            lox_reg  <= lo_x;
            hix_reg  <= hi_x;
            loy_reg  <= lo_y;
            hiy_reg  <= hi_y;
            dx12_reg <= x1 - x2;
            dx23_reg <= x2 - x3;
            dx31_reg <= x3 - x1;
            dy12_reg <= y1 - y2;
            dy23_reg <= y2 - y3;
            dy31_reg <= y3 - y1;
        end
    end

endmodule
`default_nettype wire

/* src/trd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_queue: task queue between setup and pixel engine
// Two-entry FIFO so setup can run ahead while the pixel engine is busy.
// ----------------------------------------------------------------------------
module trd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  trd_pkg::task_t push_task,
    output logic           full,
    input  logic           pop,
    output trd_pkg::task_t head,
    output logic           valid
);
    import trd_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    task_t           ent_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, rp_reg;
    logic [Q_AW:0]   cnt_reg;

    assign full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wp_reg] <= push_task;
    end

endmodule
`default_nettype wire

/* src/trd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_back: pixel engine with color and depth stores
// Clears the stores after reset, then walks draw boxes pixel by pixel with
// incremental edge values, interpolates depth, and runs fills and reads.
// ----------------------------------------------------------------------------
module trd_back #(
    parameter int MAX_WIDTH  = trd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  trd_pkg::frame_t     frame,
    input  logic                q_valid,
    input  trd_pkg::task_t      q_task,
    output logic                pop,
    output trd_pkg::back_stat_t bstat,
    output logic                m_valid,
    input  logic                m_ready,
    output trd_pkg::result_t    m_res
);
    import trd_pkg::*;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int RIX_W      = (ADDR_W > RIDX_W) ? ADDR_W + 1 : RIDX_W + 1;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam logic [RIX_W-1:0]  STORE_SIZE_R = RIX_W'(STORE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STORE_SIZE - 1);

    color_t color_mem [STORE_SIZE];
    z_t     depth_mem [STORE_SIZE];
    color_t rd_color_reg;
    z_t     rd_depth_reg;

    bst_e               state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg;
    task_t              tsk_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    edge_t              e1_reg, e2_reg, e3_reg, r1_reg, r2_reg, r3_reg;
    logic [1:0]         k_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic [63:0]        rem_reg, dsh_reg;
    logic [31:0]        aden_reg;
    logic [DIV_STEPS-1:0] q_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic               neg_reg, sat_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RIX_W-1:0]   rix_reg;
    logic               out_valid_reg;
    result_t            res_reg;

    logic               we_c, we_d, re, adv, load_out;
    logic [ADDR_W-1:0]  waddr, raddr, pix_addr;
    color_t             wcolor;
    z_t                 wdepth;
    logic               covered, last_xd, last_yd, last_xf, last_yf, sat, dwrite;
    z_t                 mz, qv;
    edge_t              me;
    logic signed [63:0] prod_next;
    logic [63:0]        anum;
    logic [31:0]        aden;

    always_comb begin
        pix_addr = ADDR_W'(32'(y_reg) * MAX_WIDTH + 32'(x_reg));
        covered  = (e1_reg > 0 && e2_reg > 0 && e3_reg > 0) ||
                   (e1_reg <= 0 && e2_reg <= 0 && e3_reg <= 0);
        last_xd  = (x_reg == tsk_reg.hi_x[XW-1:0]);
        last_yd  = (y_reg == tsk_reg.hi_y[YW-1:0]);
        last_xf  = (x_reg == XW'(frame.w - FR_W'(1)));
        last_yf  = (y_reg == YW'(frame.h - FR_W'(1)));
        case (k_reg)
            2'd0: begin mz = tsk_reg.z1; me = e2_reg; end
            2'd1: begin mz = tsk_reg.z2; me = e3_reg; end
            default: begin mz = tsk_reg.z3; me = e1_reg; end
        endcase
        prod_next = mz * me;
        anum      = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
        aden      = tsk_reg.area[EDGE_W-1] ? 32'(-tsk_reg.area) : 32'(tsk_reg.area);
        sat       = rem_reg >= ({32'b0, aden_reg} << DIV_STEPS);
        if (sat_reg)      qv = neg_reg ? NEAR_DEPTH : FAR_DEPTH;
        else if (neg_reg) qv = -z_t'({1'b0, q_reg});
        else              qv = z_t'({1'b0, q_reg});
        dwrite    = qv < rd_depth_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_task.kind)
                        KIND_DRAW: state_next = q_task.skip ? ST_RES : ST_PIX;
                        KIND_FILL: state_next = (frame.w == '0 || frame.h == '0) ?
                                                ST_RES : ST_FILL;
                        KIND_READ: state_next = ST_MOD;
                        default:   state_next = ST_RES;
                    endcase
                end
            end
            ST_MOD:  if (rix_reg < STORE_SIZE_R) state_next = ST_RD;
            ST_RD:   state_next = ST_RES;
            ST_RES:  if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            ST_FILL: if (last_xf && last_yf) state_next = ST_RES;
            ST_PIX: begin
                if (covered)                 state_next = ST_MUL;
                else if (last_xd && last_yd) state_next = ST_RES;
            end
            ST_MUL:  if (k_reg == 2'd3) state_next = ST_ABS;
            ST_ABS:  state_next = ST_SAT;
            ST_SAT:  state_next = sat ? ST_CMP : ST_DIV;
            ST_DIV:  if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) state_next = ST_CMP;
            ST_CMP:  state_next = (last_xd && last_yd) ? ST_RES : ST_PIX;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop      = 1'b0;
        we_c     = 1'b0;
        we_d     = 1'b0;
        re       = 1'b0;
        adv      = 1'b0;
        load_out = 1'b0;
        waddr    = pix_addr;
        raddr    = pix_addr;
        wcolor   = tsk_reg.color;
        wdepth   = qv;
        case (state_reg)
            ST_CLEAR: begin
                we_c   = 1'b1;
                we_d   = 1'b1;
                waddr  = clr_reg;
                wcolor = '0;
                wdepth = FAR_DEPTH;
            end
            ST_IDLE: pop = q_valid;
            ST_RD: begin
                re    = 1'b1;
                raddr = rix_reg[ADDR_W-1:0];
            end
            ST_RES:  load_out = !out_valid_reg || m_ready;
            ST_FILL: we_c = 1'b1;
            ST_PIX: begin
                re  = covered;
                adv = !covered;
            end
            ST_CMP: begin
                we_c = dwrite;
                we_d = dwrite;
                adv  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we_c) color_mem[waddr] <= wcolor;
        if (we_d) depth_mem[waddr] <= wdepth;
        if (re) begin
            rd_color_reg <= color_mem[raddr];
            rd_depth_reg <= depth_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (load_out)     out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    tsk_reg <= q_task;
                    x_reg   <= (q_task.kind == KIND_FILL) ? '0 : q_task.lo_x[XW-1:0];
                    y_reg   <= (q_task.kind == KIND_FILL) ? '0 : q_task.lo_y[YW-1:0];
                    e1_reg  <= q_task.e1;
                    e2_reg  <= q_task.e2;
                    e3_reg  <= q_task.e3;
                    r1_reg  <= q_task.e1;
                    r2_reg  <= q_task.e2;
                    r3_reg  <= q_task.e3;
                    cnt_reg <= '0;
                    rix_reg <= RIX_W'(q_task.read_index);
                end
            end
            ST_MOD: if (rix_reg >= STORE_SIZE_R) rix_reg <= rix_reg - STORE_SIZE_R;
            ST_FILL: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_xf) begin
                    x_reg <= '0;
                    y_reg <= y_reg + 1'b1;
                end else begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            ST_PIX: begin
                k_reg   <= '0;
                acc_reg <= '0;
            end
            ST_MUL: begin
                if (k_reg != 2'd3) prod_reg <= prod_next;
                if (k_reg != 2'd0) acc_reg  <= acc_reg + prod_reg;
                k_reg <= k_reg + 1'b1;
            end
            ST_ABS: begin
                rem_reg  <= anum;
                aden_reg <= aden;
                neg_reg  <= acc_reg[63] ^ tsk_reg.area[EDGE_W-1];
            end
            ST_SAT: begin
                sat_reg  <= sat;
                dsh_reg  <= {32'b0, aden_reg} << (DIV_STEPS - 1);
                q_reg    <= '0;
                dcnt_reg <= '0;
            end
            ST_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b0};
                end
                dsh_reg  <= dsh_reg >> 1;
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            ST_CMP: if (dwrite) cnt_reg <= cnt_reg + 1'b1;
            default: ;
        endcase

        // step to the next pixel of the box, row-major
        if (adv) begin
            if (last_xd) begin
                x_reg  <= tsk_reg.lo_x[XW-1:0];
                y_reg  <= y_reg + 1'b1;
                r1_reg <= r1_reg - edge_t'(tsk_reg.dx12);
                r2_reg <= r2_reg - edge_t'(tsk_reg.dx23);
                r3_reg <= r3_reg - edge_t'(tsk_reg.dx31);
                e1_reg <= r1_reg - edge_t'(tsk_reg.dx12);
                e2_reg <= r2_reg - edge_t'(tsk_reg.dx23);
                e3_reg <= r3_reg - edge_t'(tsk_reg.dx31);
            end else begin
                x_reg  <= x_reg + 1'b1;
                e1_reg <= e1_reg + edge_t'(tsk_reg.dy12);
                e2_reg <= e2_reg + edge_t'(tsk_reg.dy23);
                e3_reg <= e3_reg + edge_t'(tsk_reg.dy31);
            end
        end

        if (load_out) begin
            if (tsk_reg.kind == KIND_READ) begin
                res_reg.pixel_color    <= rd_color_reg;
                res_reg.pixel_depth    <= rd_depth_reg;
                res_reg.pixels_written <= '0;
            end else begin
                res_reg.pixel_color    <= '0;
                res_reg.pixel_depth    <= '0;
                res_reg.pixels_written <= cnt_reg;
            end
        end
    end

    assign bstat.clearing = (state_reg == ST_CLEAR);
    assign m_valid        = out_valid_reg;
    assign m_res          = res_reg;

    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !pop)
        else $error("task taken during store clear");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(we_c || we_d))
        else $error("store written while idle");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dcnt_reg < DCNT_W'(DIV_STEPS)))
        else $error("divider ran past its last step");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP && !sat_reg) |-> (rem_reg < {32'b0, aden_reg}))
        else $error("division remainder not below divisor");

endmodule
`default_nettype wire

/* tb/trd_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_scoreboard: frame store predictor and result checker
// Follows the config writes and the accepted input words, keeps its own color
// and depth stores, and checks every result word against the oldest
// predicted one.
// ----------------------------------------------------------------------------
module trd_scoreboard
    import trd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [207:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [79:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           errors,
    output int           pending
);

    localparam int NPIX = 65536;
    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    color_t           pix_color [NPIX];
    logic signed [31:0] pix_depth [NPIX];
    logic [8:0]       width_reg;
    logic [8:0]       height_reg;
    result_t          result_q[$];

    function automatic longint eff_w();
        return (width_reg > 256) ? 256 : width_reg;
    endfunction

    function automatic longint eff_h();
        return (height_reg > 256) ? 256 : height_reg;
    endfunction

    function automatic longint sx12(logic [11:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint min3(longint a, longint b, longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint max3(longint a, longint b, longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // rasterize one triangle into the model stores, return pixels changed
    task automatic raster_triangle(input logic [207:0] d, output longint cnt);
        longint x1, y1, z1, x2, y2, z2, x3, y3, z3;
        longint lx, hx, ly, hy, dx12, dx23, dx31, dy12, dy23, dy31;
        longint c12, c23, c31, area, s1, s2, s3, q;
        int idx;
        x1 = sx12(d[11:0]);    y1 = sx12(d[23:12]);   z1 = longint'($signed(d[55:24]));
        x2 = sx12(d[67:56]);   y2 = sx12(d[79:68]);   z2 = longint'($signed(d[111:80]));
        x3 = sx12(d[123:112]); y3 = sx12(d[135:124]); z3 = longint'($signed(d[167:136]));
        cnt = 0;
        lx = min3(x1, x2, x3); hx = max3(x1, x2, x3);
        ly = min3(y1, y2, y3); hy = max3(y1, y2, y3);
        dx12 = x1 - x2; dx23 = x2 - x3; dx31 = x3 - x1;
        dy12 = y1 - y2; dy23 = y2 - y3; dy31 = y3 - y1;
        c12 = dx12 * y2 - dy12 * x2;
        c23 = dx23 * y3 - dy23 * x3;
        c31 = dx31 * y1 - dy31 * x1;
        area = dy31 * dx23 - dx31 * dy23;
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (hx > eff_w() - 1) hx = eff_w() - 1;
        if (hy > eff_h() - 1) hy = eff_h() - 1;
        if (area == 0) return;
        for (longint y = ly; y <= hy; y++) begin
            for (longint x = lx; x <= hx; x++) begin
                s1 = dy12 * x - dx12 * y + c12;
                s2 = dy23 * x - dx23 * y + c23;
                s3 = dy31 * x - dx31 * y + c31;
                if ((s1 > 0 && s2 > 0 && s3 > 0) || (s1 <= 0 && s2 <= 0 && s3 <= 0)) begin
                    q = (z1 * s2 + z2 * s3 + z3 * s1) / area;
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    idx = int'(y) * 256 + int'(x);
                    if (q < longint'(pix_depth[idx])) begin
                        pix_color[idx] = d[191:168];
                        pix_depth[idx] = q[31:0];
                        cnt++;
                    end
                end
            end
        end
    endtask

    task automatic predict_word(input kind_e k, input logic [207:0] d);
        result_t r;
        longint cnt;
        int idx;
        r = '0;
        case (k)
            KIND_DRAW: begin
                raster_triangle(d, cnt);
                r.pixels_written = cnt[16:0];
            end
            KIND_FILL: begin
                for (longint y = 0; y < eff_h(); y++)
                    for (longint x = 0; x < eff_w(); x++)
                        pix_color[int'(y) * 256 + int'(x)] = d[191:168];
                cnt = eff_w() * eff_h();
                r.pixels_written = cnt[16:0];
            end
            KIND_READ: begin
                idx = int'(d[207:192]);
                r.pixel_color = pix_color[idx];
                r.pixel_depth = pix_depth[idx];
            end
            default: ;
        endcase
        result_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < NPIX; i++) begin
                pix_color[i] = '0;
                pix_depth[i] = FAR_DEPTH;
            end
            width_reg  = 9'd256;
            height_reg = 9'd256;
            result_q.delete();
            errors     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_WIDTH)  width_reg  = pwdata[8:0];
                if (paddr == ADDR_HEIGHT) height_reg = pwdata[8:0];
            end
            if (s_tvalid && s_tready)
                predict_word(kind_e'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                got = m_tdata[72:0];
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, got);
                end else begin
                    want = result_q.pop_front();
                    if (got.pixel_color !== want.pixel_color) begin
                        errors++;
                        $display("%0t: pixel_color exp %h got %h",
                                 $time, want.pixel_color, got.pixel_color);
                    end
                    if (got.pixel_depth !== want.pixel_depth) begin
                        errors++;
                        $display("%0t: pixel_depth exp %h got %h",
                                 $time, want.pixel_depth, got.pixel_depth);
                    end
                    if (got.pixels_written !== want.pixels_written) begin
                        errors++;
                        $display("%0t: pixels_written exp %0d got %0d",
                                 $time, want.pixels_written, got.pixels_written);
                    end
                end
            end
        end
        pending = result_q.size();
    end

    initial begin
        errors  = 0;
        pending = 0;
    end

endmodule

/* tb/triangle_raster_depth_test_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_raster_depth_test_tb: stimulus and verdict
// Directed draw/fill/read words and random words with small triangles over
// several frame sizes, random gaps and back-pressure; the scoreboard checks.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test_tb;
    import trd_pkg::*;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam int WATCHDOG_LIMIT = 1000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           errors, pending;
    int           idle_cycles = 0;
    int           cur_w = 256, cur_h = 256;
    int           n_draw = 0, n_fill = 0, n_read = 0, n_nop = 0, n_cfg = 0;
    int           rd_hold = 0;

    always #5 aclk = ~aclk;

    triangle_raster_depth_test dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    trd_scoreboard chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .errors, .pending
    );

    // result side back-pressure: runs of ready, short stalls, rare long ones
    always @(posedge aclk) begin
        int r;
        if (rd_hold > 0) begin
            rd_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready <= 1'b1;
                rd_hold = $urandom_range(0, 10);
            end else if (r < 95) begin
                m_tready <= 1'b0;
                rd_hold = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                rd_hold = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("FAIL triangle_raster_depth_test");
            $finish;
        end
    end

    function automatic logic [11:0] crd(int v);
        if (v < -2048) v = -2048;
        if (v > 2047) v = 2047;
        return v[11:0];
    endfunction

    function automatic item_t rand_fields(kind_e k);
        item_t it;
        it = '0;
        it.kind = k;
        it.x1 = 12'($urandom); it.y1 = 12'($urandom); it.z1 = $urandom;
        it.x2 = 12'($urandom); it.y2 = 12'($urandom); it.z2 = $urandom;
        it.x3 = 12'($urandom); it.y3 = 12'($urandom); it.z3 = $urandom;
        it.color = 24'($urandom);
        it.read_index = 16'($urandom);
        return it;
    endfunction

    function automatic item_t mk_draw(int x1, int y1, int z1, int x2, int y2, int z2,
                                      int x3, int y3, int z3, logic [23:0] c);
        item_t it;
        it = rand_fields(KIND_DRAW);
        it.x1 = crd(x1); it.y1 = crd(y1); it.z1 = z1;
        it.x2 = crd(x2); it.y2 = crd(y2); it.z2 = z2;
        it.x3 = crd(x3); it.y3 = crd(y3); it.z3 = z3;
        it.color = c;
        return it;
    endfunction

    function automatic item_t mk_fill(logic [23:0] c);
        item_t it;
        it = rand_fields(KIND_FILL);
        it.color = c;
        return it;
    endfunction

    function automatic item_t mk_read(int x, int y);
        item_t it;
        it = rand_fields(KIND_READ);
        it.read_index = 16'((y << 8) + x);
        return it;
    endfunction

    // called at a rising edge; returns at the edge that took the word, or after a random idle gap
    task automatic send_word(item_t it);
        int g;
        case (it.kind)
            KIND_DRAW: n_draw++;
            KIND_FILL: n_fill++;
            KIND_READ: n_read++;
            default:   n_nop++;
        endcase
        s_tdata  <= {it.read_index, it.color, it.z3, it.y3, it.x3,
                     it.z2, it.y2, it.x2, it.z1, it.y1, it.x1};
        s_tuser  <= it.kind;
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        g = $urandom_range(0, 99);
        if (g >= 50) begin
            s_tvalid <= 1'b0;
            repeat ((g < 95) ? $urandom_range(1, 3) : $urandom_range(20, 80))
                @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] a, logic [31:0] v);
        n_cfg++;
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(int w, int h);
        wait_idle();
        apb_write(ADDR_WIDTH, w);
        apb_write(ADDR_HEIGHT, h);
        cur_w = (w > 256) ? 256 : w;
        cur_h = (h > 256) ? 256 : h;
    endtask

    function automatic int rand_z();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 2000) * 64 - 64000;
    endfunction

    task automatic random_words(int n);
        item_t it;
        int k, bx, by, sz;
        bit small_frame;
        small_frame = (cur_w * cur_h <= 4096);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 55) begin
                sz = $urandom_range(1, 8);
                bx = $urandom_range(0, cur_w + 6) - 3;
                by = $urandom_range(0, cur_h + 6) - 3;
                if (small_frame && $urandom_range(0, 4) == 0)
                    it = rand_fields(KIND_DRAW);
                else
                    it = mk_draw(bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
                                 rand_z(),
                                 bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
                                 rand_z(),
                                 bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
                                 rand_z(), 24'($urandom));
            end else if (k < 62 && small_frame) begin
                it = mk_fill(24'($urandom));
            end else if (k < 95) begin
                if ($urandom_range(0, 3) == 0)
                    it = rand_fields(KIND_READ);
                else
                    it = mk_read($urandom_range(0, (cur_w > 0) ? cur_w - 1 : 0),
                                 $urandom_range(0, (cur_h > 0) ? cur_h - 1 : 0));
            end else begin
                it = rand_fields(KIND_NOP);
            end
            send_word(it);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset contents, unused kind, both windings, depth test, degenerate
        send_word(mk_read(0, 0));
        send_word(mk_read(255, 255));
        send_word(rand_fields(KIND_NOP));
        send_word(mk_draw(2, 2, 32'h0001_0000, 12, 3, 32'h0002_0000, 4, 11,
                          32'h0003_0000, 24'hff0000));
        send_word(mk_draw(2, 2, 32'h0000_8000, 4, 11, 32'h0000_8000, 12, 3,
                          32'h8000_0000, 24'h00ff00));
        send_word(mk_draw(2, 2, 32'h7fff_ffff, 12, 3, 32'h7fff_ffff, 4, 11,
                          32'h7fff_ffff, 24'h0000ff));
        send_word(mk_draw(0, 0, 0, 5, 5, 0, 10, 10, 0, 24'hffffff));
        send_word(mk_draw(-30, -30, 0, -10, -25, 0, -20, -5, 0, 24'h123456));
        send_word(mk_read(4, 4));
        send_word(mk_read(8, 5));

        // coordinate extremes clipped to a small frame, then fill
        set_frame(16, 16);
        send_word(mk_draw(-2048, -2048, 32'h7fff_ffff, 2047, -2048, 32'h8000_0000,
                          -2048, 2047, 32'h0, 24'habcdef));
        send_word(mk_draw(2047, 2047, 32'h100, 2047, -2048, 32'h100, -2048, 2047,
                          32'h100, 24'h55aa55));
        send_word(mk_fill(24'hffffff));
        send_word(mk_read(15, 15));
        send_word(mk_read(16, 0));
        random_words(25);

        // empty frame
        set_frame(0, 0);
        send_word(mk_draw(0, 0, 0, 8, 0, 0, 0, 8, 0, 24'h0f0f0f));
        send_word(mk_fill(24'h000000));
        random_words(5);

        // one column, then one row
        set_frame(1, 256);
        random_words(10);
        set_frame(256, 1);
        random_words(8);

        // oversized registers saturate to the full frame
        set_frame(511, 511);
        send_word(mk_fill(24'h102030));
        send_word(mk_read(255, 255));
        random_words(25);

        set_frame(20, 12);
        random_words(30);

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("Covered %0d draws, %0d fills, %0d reads, %0d unused-kind words,",
                 n_draw, n_fill, n_read, n_nop);
        $display("over %0d register writes from empty to saturated frame sizes.", n_cfg);
        if (errors == 0) begin
            $display("PASS triangle_raster_depth_test");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL triangle_raster_depth_test");
        end
        $finish;
    end

endmodule
